[rtl/core/priority_scheduler_with_aging_macros.svh]
// ----------------------------------------------------------------------------
// Priority scheduler assertion macros
// Shared concurrent assertion shorthands, all clocked on clk and muted in rst.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULER_WITH_AGING_MACROS_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_MACROS_SVH

// same-cycle implication
`define PSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/psa_pkg.sv]
// ----------------------------------------------------------------------------
// psa_pkg
// Sizes, structs and codes shared by the scheduler cells and the top level.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_BITS = 4;
  localparam int PRIO_BITS = 8;
  localparam int AGE_BITS  = 8;
  localparam int REM_BITS  = 16;
  localparam int CNT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  // register indexes
  localparam logic REG_AGING_LIMIT  = 1'b0;
  localparam logic REG_PREEMPT_MODE = 1'b1;

  // configuration held by the register block
  typedef struct packed {
    logic [AGE_BITS-1:0] aging_limit;
    logic                preempt_mode;
  } cfg_t;

  // candidate handed down the cell chain during a search
  typedef struct packed {
    logic                 vld;
    logic [PRIO_BITS-1:0] prio;
    logic [SLOT_BITS-1:0] slot;
  } cand_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                 load;
    logic [SLOT_BITS-1:0] load_slot;
    logic [PRIO_BITS-1:0] load_prio;
    logic [REM_BITS-1:0]  load_burst;
    logic                 run;
    logic [SLOT_BITS-1:0] run_slot;
    logic                 age_en;
    logic [AGE_BITS-1:0]  aging_limit;
  } cell_ctl_t;

endpackage

[rtl/core/psa_regs.sv]
// ----------------------------------------------------------------------------
// psa_regs
// APB register block: aging limit and preemption mode.
// ----------------------------------------------------------------------------
module psa_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output psa_pkg::cfg_t       cfg
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aging_limit  <= psa_pkg::AGE_BITS'(5);
      cfg.preempt_mode <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        psa_pkg::REG_AGING_LIMIT:  cfg.aging_limit  <= pwdata[psa_pkg::AGE_BITS-1:0];
        psa_pkg::REG_PREEMPT_MODE: cfg.preempt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      psa_pkg::REG_AGING_LIMIT:  prdata = {{(32-psa_pkg::AGE_BITS){1'b0}}, cfg.aging_limit};
      psa_pkg::REG_PREEMPT_MODE: prdata = {31'b0, cfg.preempt_mode};
      default:                   prdata = 32'b0;
    endcase
  end

endmodule

[rtl/core/psa_cell.sv]
// ----------------------------------------------------------------------------
// psa_cell
// One task slot: holds live, priority, age and remaining burst, and passes
// the best candidate seen so far to its neighbor every cycle.
// ----------------------------------------------------------------------------
`include "priority_scheduler_with_aging_macros.svh"

module psa_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [psa_pkg::SLOT_BITS-1:0]    my_idx,
  input  psa_pkg::cell_ctl_t               ctl,
  input  psa_pkg::cand_t                   best_in,
  output psa_pkg::cand_t                   best_out,
  output logic                             live,
  output logic                             last
);

  logic [psa_pkg::PRIO_BITS-1:0] prio;
  logic [psa_pkg::AGE_BITS-1:0]  age;
  logic [psa_pkg::REM_BITS-1:0]  remaining;
  logic [psa_pkg::AGE_BITS-1:0]  age_inc;
  logic                          take_own;
  logic                          is_run;

  assign last     = (remaining == psa_pkg::REM_BITS'(1));
  assign age_inc  = age + psa_pkg::AGE_BITS'(1);
  assign is_run   = ctl.run && (ctl.run_slot == my_idx);
  // strict less-than keeps the lower slot on a tie
  assign take_own = live && (!best_in.vld || (prio < best_in.prio));

  // candidate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      best_out.vld <= 1'b0;
    end else begin
      best_out.vld <= best_in.vld | take_own;
    end
    best_out.prio <= take_own ? prio : best_in.prio;
    best_out.slot <= take_own ? my_idx : best_in.slot;
  end

  // live flag
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (ctl.load && (ctl.load_slot == my_idx)) begin
      live <= (ctl.load_burst != '0);
    end else if (is_run && last) begin
      live <= 1'b0;
    end
  end

  // slot payload: load, run, aging
  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.load_slot == my_idx)) begin
      prio      <= ctl.load_prio;
      age       <= '0;
      remaining <= ctl.load_burst;
    end else begin
      if (is_run) begin
        remaining <= remaining - psa_pkg::REM_BITS'(1);
      end
      if (ctl.age_en && live && !is_run) begin
        if (age_inc >= ctl.aging_limit) begin
          age <= '0;
          if (prio != '0) begin
            prio <= prio - psa_pkg::PRIO_BITS'(1);
          end
        end else begin
          age <= age_inc;
        end
      end
    end
  end

  `PSA_ASSERT_NOW(a_live_has_work, live, remaining != '0, "live slot with no remaining burst")
  `PSA_ASSERT_NEXT(a_out_vld_sticky, best_in.vld, best_out.vld, "candidate lost in chain")
  `PSA_ASSERT_NEXT(a_run_last_clears, is_run && last && !ctl.load, !live,
                   "finished slot still live")

endmodule

[rtl/core/priority_scheduler_with_aging.sv]
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging
// Sixteen-slot priority scheduler with aging, driven by add and tick words.
// ----------------------------------------------------------------------------
// An add word (cmd 1) loads a slot in the cycle it is taken and busy stays
// low. A tick word (cmd 0) raises busy while the minimum-priority search
// walks the row of slot cells one cell per cycle and then the apply state
// applies the run, aging and completion. The result word is shown on
// run_slot/idle/finished/switched for exactly one cycle with done high, in
// the first cycle with busy low; the receiver cannot stall it, and the next
// word may be started in that same cycle. Registers: aging_limit at byte 0,
// preempt_mode at byte 4.
`include "priority_scheduler_with_aging_macros.svh"

module priority_scheduler_with_aging (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [3:0]                     slot,
  input  logic [7:0]                     prio_value,
  input  logic [15:0]                    burst,
  output logic                           done,
  output logic [3:0]                     run_slot,
  output logic                           idle,
  output logic                           finished,
  output logic                           switched
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_APPLY  = 2'd2;

  psa_pkg::cfg_t                   cfg;
  psa_pkg::cell_ctl_t              ctl;
  psa_pkg::cand_t                  chain [psa_pkg::NUM_SLOTS+1];
  psa_pkg::cand_t                  best;
  logic [psa_pkg::NUM_SLOTS-1:0]   live_vec;
  logic [psa_pkg::NUM_SLOTS-1:0]   last_vec;

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [psa_pkg::CNT_BITS-1:0]    cnt;
  logic [psa_pkg::SLOT_BITS-1:0]   cur_slot;
  logic                            cur_valid;

  logic                            accept;
  logic                            is_add;
  logic                            keep;
  logic                            any;
  logic [psa_pkg::SLOT_BITS-1:0]   sel;
  logic                            fin;
  logic                            applying;

  // configuration registers
  psa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // row of slot cells
  assign chain[0] = '0;
  for (genvar i = 0; i < psa_pkg::NUM_SLOTS; i++) begin : g_cell
    psa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_idx   (psa_pkg::SLOT_BITS'(i)),
      .ctl      (ctl),
      .best_in  (chain[i]),
      .best_out (chain[i+1]),
      .live     (live_vec[i]),
      .last     (last_vec[i])
    );
  end
  assign best = chain[psa_pkg::NUM_SLOTS];

  // handshake
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign is_add   = accept && (cmd == psa_pkg::CMD_ADD);
  assign applying = (state == ST_APPLY);

  // dispatch decision
  assign keep = !cfg.preempt_mode && cur_valid && live_vec[cur_slot];
  assign any  = keep || best.vld;
  assign sel  = keep ? cur_slot : best.slot;
  assign fin  = any && last_vec[sel];

  // broadcast to cells
  always_comb begin
    ctl.load        = is_add;
    ctl.load_slot   = slot;
    ctl.load_prio   = prio_value[psa_pkg::PRIO_BITS-1:0];
    ctl.load_burst  = burst;
    ctl.run         = applying && any;
    ctl.run_slot    = sel;
    ctl.age_en      = applying && any && (cfg.preempt_mode || fin);
    ctl.aging_limit = cfg.aging_limit;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd == psa_pkg::CMD_TICK)) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cnt == psa_pkg::CNT_BITS'(psa_pkg::NUM_SLOTS - 1)) state_next = ST_APPLY;
      end
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SEARCH) begin
        cnt <= cnt + psa_pkg::CNT_BITS'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // running task
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot  <= '0;
      cur_valid <= 1'b0;
    end else if (is_add) begin
      if ((burst == '0) && (cur_slot == slot)) cur_valid <= 1'b0;
    end else if (applying && any) begin
      cur_slot  <= sel;
      cur_valid <= !fin;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= applying;
    end
    if (applying) begin
      run_slot <= any ? sel : '0;
      idle     <= !any;
      finished <= fin;
      switched <= any && !(cur_valid && (cur_slot == sel));
    end
  end

  `PSA_ASSERT_NOW(a_done_not_busy, done, !busy, "result shown while busy")
  `PSA_ASSERT_NOW(a_idle_word, done && idle, !finished && !switched && (run_slot == '0),
                  "idle tick with activity")
  `PSA_ASSERT_NOW(a_finish_drops_cur, done && finished, !cur_valid,
                  "finished task still current")
  `PSA_ASSERT_NEXT(a_tick_goes_busy, accept && (cmd == psa_pkg::CMD_TICK), busy,
                   "tick word did not start a search")

endmodule
